// ----- hdl/ec_scalar_multiply_gfp_macros.svh -----
// Assertion helpers shared by the scalar multiplier files.
// They expect clk and rst_n in the scope where they are used.
`ifndef EC_SCALAR_MULTIPLY_GFP_MACROS_SVH
`define EC_SCALAR_MULTIPLY_GFP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ecsm_pkg.sv -----
package ecsm_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_CURVE_A = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRIME_P = 1'd1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_X,
    ST_RED_Y,
    ST_RED_A,
    ST_FIND,
    ST_LOOP,
    ST_DBL_CHK,
    ST_D_SQ,
    ST_D_T1,
    ST_D_T2,
    ST_D_T3,
    ST_D_TV,
    ST_ADD_CHK,
    ST_A_TV,
    ST_A_T1,
    ST_INV_INIT,
    ST_INV_SQ,
    ST_INV_MUL,
    ST_LAM,
    ST_X_SQ,
    ST_X_S1,
    ST_X_S2,
    ST_Y_D,
    ST_Y_M,
    ST_Y_S,
    ST_FIN
  } state_t;

endpackage

// ----- hdl/ecsm_alu.sv -----
`include "ec_scalar_multiply_gfp_macros.svh"

module ecsm_alu
  import ecsm_pkg::*;
#(
  parameter int FIELD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  alu_req_t              req,
  input  logic [FIELD_BITS-1:0] opa,
  input  logic [FIELD_BITS-1:0] opb,
  input  logic [FIELD_BITS-1:0] modulus,
  output alu_stat_t             stat,
  output logic [FIELD_BITS-1:0] res
);

  localparam int CW = $clog2(FIELD_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  ph_r, ph_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [FIELD_BITS-1:0] acc_r, acc_nxt;
  logic [FIELD_BITS-1:0] av_r, av_nxt;
  logic [FIELD_BITS-1:0] bsh_r, bsh_nxt;
  logic [FIELD_BITS-1:0] y_r, y_nxt;

  logic [FIELD_BITS-1:0] add_x, add_y, add_s;
  logic [FIELD_BITS:0]   sum_w;

  // One modular add per cycle; operands are below the modulus.
  assign sum_w = {1'b0, add_x} + {1'b0, add_y};
  assign add_s = (sum_w >= {1'b0, modulus}) ? FIELD_BITS'(sum_w - {1'b0, modulus})
                                            : sum_w[FIELD_BITS-1:0];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    av_nxt   = av_r;
    bsh_nxt  = bsh_r;
    y_nxt    = y_r;
    add_x    = opa;
    add_y    = opb;
    if (busy_r) begin
      add_x = acc_r;
      add_y = ph_r ? av_r : acc_r;
    end
    if (req.start && !busy_r) begin
      case (req.op)
        ALU_ADD: begin
          y_nxt    = add_s;
          done_nxt = 1'b1;
        end
        ALU_SUB: begin
          y_nxt    = (opa >= opb) ? (opa - opb) : (opa - opb + modulus);
          done_nxt = 1'b1;
        end
        ALU_MUL: begin
          busy_nxt = 1'b1;
          acc_nxt  = '0;
          av_nxt   = opa;
          bsh_nxt  = opb;
          cnt_nxt  = CW'(FIELD_BITS);
          ph_nxt   = 1'b0;
        end
        default: begin
          done_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      // Each multiplier bit takes a doubling step and then a conditional add step.
      if (!ph_r) begin
        acc_nxt = add_s;
        ph_nxt  = 1'b1;
      end else begin
        if (bsh_r[FIELD_BITS-1]) begin
          acc_nxt = add_s;
        end
        bsh_nxt = bsh_r << 1;
        ph_nxt  = 1'b0;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          y_nxt    = bsh_r[FIELD_BITS-1] ? add_s : acc_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    av_r  <= av_nxt;
    bsh_r <= bsh_nxt;
    y_r   <= y_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = y_r;

  `ECSM_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "ALU done held for two cycles")
  `ECSM_ASSERT_SAME(a_res_reduced, done_r && (modulus != '0), y_r < modulus, "ALU result not reduced")

endmodule

// ----- hdl/ec_scalar_multiply_gfp.sv -----
// Affine elliptic-curve scalar multiplier over GF(p), left-to-right double-and-add.
// The point at infinity is (0,0); a zero scalar or zero modulus gives (0,0).
// All field work goes through one bit-serial modular ALU. Each inversion is an
// exponentiation to p-2 of FIELD_BITS squarings plus one multiply per set
// exponent bit, so one point doubling costs (FIELD_BITS + popcount(p-2) + 4)
// multiplies and a point addition one fewer. A scalar takes up to about
// 2 * (SCALAR_BITS-1) point operations. One word is processed at a time; a new
// word is taken once the previous result has been loaded into the output
// register.
`include "ec_scalar_multiply_gfp_macros.svh"

module ec_scalar_multiply_gfp
  import ecsm_pkg::*;
#(
  parameter int FIELD_BITS  = 64,
  parameter int SCALAR_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FIELD_BITS-1:0]  in_point_x,
  input  logic [FIELD_BITS-1:0]  in_point_y,
  input  logic [SCALAR_BITS-1:0] in_scalar,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FIELD_BITS-1:0]  out_result_x,
  output logic [FIELD_BITS-1:0]  out_result_y,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]  cfg_data
);

  localparam int KW = $clog2(SCALAR_BITS);
  localparam int EW = $clog2(FIELD_BITS + 1);

  state_t                 state_r, state_nxt;
  logic                   issued_r, issued_nxt;
  logic                   add_pend_r, add_pend_nxt;
  logic                   is_add_r, is_add_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [KW-1:0]          cnt_r, cnt_nxt;
  logic [SCALAR_BITS-1:0] ks_r, ks_nxt;
  logic [EW-1:0]          ecnt_r, ecnt_nxt;
  logic [FIELD_BITS-1:0]  esh_r, esh_nxt;
  logic [FIELD_BITS-1:0]  curve_a_r, prime_p_r;
  logic [FIELD_BITS-1:0]  bx_r, bx_nxt, by_r, by_nxt, ar_r, ar_nxt;
  logic [FIELD_BITS-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  logic [FIELD_BITS-1:0]  t0_r, t0_nxt, t1_r, t1_nxt, tv_r, tv_nxt;
  logic [FIELD_BITS-1:0]  tinv_r, tinv_nxt, lam_r, lam_nxt;
  logic [FIELD_BITS-1:0]  resx_r, resx_nxt, resy_r, resy_nxt;

  alu_req_t              alu_req;
  alu_stat_t             alu_stat;
  logic [FIELD_BITS-1:0] alu_a, alu_b, alu_y;
  logic                  alu_state;
  logic [FIELD_BITS-1:0] one_m, neg_by;

  // With a modulus of one every residue is zero, including "one".
  assign one_m  = (prime_p_r == FIELD_BITS'(1)) ? '0 : FIELD_BITS'(1);
  assign neg_by = (by_r == '0) ? '0 : (prime_p_r - by_r);

  ecsm_alu #(.FIELD_BITS(FIELD_BITS)) u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (alu_req),
    .opa     (alu_a),
    .opb     (alu_b),
    .modulus (prime_p_r),
    .stat    (alu_stat),
    .res     (alu_y)
  );

  // Operand selection for the states that run an ALU operation.
  always_comb begin
    alu_state  = 1'b1;
    alu_req.op = ALU_MUL;
    alu_a      = t0_r;
    alu_b      = t0_r;
    case (state_r)
      ST_RED_X:   begin alu_a = one_m;  alu_b = bx_r; end
      ST_RED_Y:   begin alu_a = one_m;  alu_b = by_r; end
      ST_RED_A:   begin alu_a = one_m;  alu_b = ar_r; end
      ST_D_SQ:    begin alu_a = rx_r;   alu_b = rx_r; end
      ST_D_T1:    begin alu_req.op = ALU_ADD; alu_a = t0_r; alu_b = t0_r; end
      ST_D_T2:    begin alu_req.op = ALU_ADD; alu_a = t1_r; alu_b = t0_r; end
      ST_D_T3:    begin alu_req.op = ALU_ADD; alu_a = t1_r; alu_b = ar_r; end
      ST_D_TV:    begin alu_req.op = ALU_ADD; alu_a = ry_r; alu_b = ry_r; end
      ST_A_TV:    begin alu_req.op = ALU_SUB; alu_a = rx_r; alu_b = bx_r; end
      ST_A_T1:    begin alu_req.op = ALU_SUB; alu_a = ry_r; alu_b = by_r; end
      ST_INV_SQ:  begin alu_a = tinv_r; alu_b = tinv_r; end
      ST_INV_MUL: begin alu_a = tinv_r; alu_b = tv_r; end
      ST_LAM:     begin alu_a = t1_r;   alu_b = tinv_r; end
      ST_X_SQ:    begin alu_a = lam_r;  alu_b = lam_r; end
      ST_X_S1:    begin alu_req.op = ALU_SUB; alu_a = t0_r; alu_b = rx_r; end
      ST_X_S2:    begin
        alu_req.op = ALU_SUB;
        alu_a      = t0_r;
        alu_b      = is_add_r ? bx_r : rx_r;
      end
      ST_Y_D:     begin alu_req.op = ALU_SUB; alu_a = rx_r; alu_b = t0_r; end
      ST_Y_M:     begin alu_a = lam_r;  alu_b = t1_r; end
      ST_Y_S:     begin alu_req.op = ALU_SUB; alu_a = t1_r; alu_b = ry_r; end
      default:    alu_state = 1'b0;
    endcase
    alu_req.start = alu_state && !issued_r;
  end

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    add_pend_nxt  = add_pend_r;
    is_add_nxt    = is_add_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    ks_nxt        = ks_r;
    ecnt_nxt      = ecnt_r;
    esh_nxt       = esh_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    ar_nxt        = ar_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    tv_nxt        = tv_r;
    tinv_nxt      = tinv_r;
    lam_nxt       = lam_r;
    resx_nxt      = resx_r;
    resy_nxt      = resy_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (alu_req.start) begin
      issued_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bx_nxt  = in_point_x;
          by_nxt  = in_point_y;
          ar_nxt  = curve_a_r;
          ks_nxt  = in_scalar;
          cnt_nxt = KW'(SCALAR_BITS - 1);
          if ((prime_p_r == '0) || (in_scalar == '0)) begin
            rx_nxt    = '0;
            ry_nxt    = '0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_RED_X;
          end
        end
      end
      ST_FIND: begin
        ks_nxt = ks_r << 1;
        if (ks_r[SCALAR_BITS-1]) begin
          rx_nxt    = bx_r;
          ry_nxt    = by_r;
          state_nxt = ST_LOOP;
        end else begin
          cnt_nxt = cnt_r - KW'(1);
        end
      end
      ST_LOOP: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt      = cnt_r - KW'(1);
          add_pend_nxt = ks_r[SCALAR_BITS-1];
          ks_nxt       = ks_r << 1;
          state_nxt    = ST_DBL_CHK;
        end
      end
      ST_DBL_CHK: begin
        is_add_nxt = 1'b0;
        if (ry_r == '0) begin
          rx_nxt    = '0;
          ry_nxt    = '0;
          state_nxt = add_pend_r ? ST_ADD_CHK : ST_LOOP;
        end else begin
          state_nxt = ST_D_SQ;
        end
      end
      ST_ADD_CHK: begin
        add_pend_nxt = 1'b0;
        if (rx_r == '0 && ry_r == '0) begin
          rx_nxt    = bx_r;
          ry_nxt    = by_r;
          state_nxt = ST_LOOP;
        end else if (bx_r == '0 && by_r == '0) begin
          state_nxt = ST_LOOP;
        end else if (rx_r == bx_r && ry_r == neg_by) begin
          rx_nxt    = '0;
          ry_nxt    = '0;
          state_nxt = ST_LOOP;
        end else if (rx_r == bx_r && ry_r == by_r) begin
          state_nxt = ST_DBL_CHK;
        end else begin
          is_add_nxt = 1'b1;
          state_nxt  = ST_A_TV;
        end
      end
      ST_INV_INIT: begin
        tinv_nxt  = one_m;
        ecnt_nxt  = EW'(FIELD_BITS);
        esh_nxt   = prime_p_r - FIELD_BITS'(2);
        state_nxt = ST_INV_SQ;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          resx_nxt      = rx_r;
          resy_nxt      = ry_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        if (alu_stat.done && issued_r) begin
          issued_nxt = 1'b0;
          case (state_r)
            ST_RED_X:   begin bx_nxt = alu_y; state_nxt = ST_RED_Y; end
            ST_RED_Y:   begin by_nxt = alu_y; state_nxt = ST_RED_A; end
            ST_RED_A:   begin ar_nxt = alu_y; state_nxt = ST_FIND; end
            ST_D_SQ:    begin t0_nxt = alu_y; state_nxt = ST_D_T1; end
            ST_D_T1:    begin t1_nxt = alu_y; state_nxt = ST_D_T2; end
            ST_D_T2:    begin t1_nxt = alu_y; state_nxt = ST_D_T3; end
            ST_D_T3:    begin t1_nxt = alu_y; state_nxt = ST_D_TV; end
            ST_D_TV:    begin tv_nxt = alu_y; state_nxt = ST_INV_INIT; end
            ST_A_TV:    begin tv_nxt = alu_y; state_nxt = ST_A_T1; end
            ST_A_T1:    begin t1_nxt = alu_y; state_nxt = ST_INV_INIT; end
            ST_INV_SQ, ST_INV_MUL: begin
              tinv_nxt = alu_y;
              if (state_r == ST_INV_SQ && esh_r[FIELD_BITS-1]) begin
                state_nxt = ST_INV_MUL;
              end else begin
                // Exponent bit finished: move on to the next one.
                esh_nxt   = esh_r << 1;
                ecnt_nxt  = ecnt_r - EW'(1);
                state_nxt = (ecnt_r == EW'(1)) ? ST_LAM : ST_INV_SQ;
              end
            end
            ST_LAM:     begin lam_nxt = alu_y; state_nxt = ST_X_SQ; end
            ST_X_SQ:    begin t0_nxt = alu_y; state_nxt = ST_X_S1; end
            ST_X_S1:    begin t0_nxt = alu_y; state_nxt = ST_X_S2; end
            ST_X_S2:    begin t0_nxt = alu_y; state_nxt = ST_Y_D; end
            ST_Y_D:     begin t1_nxt = alu_y; state_nxt = ST_Y_M; end
            ST_Y_M:     begin t1_nxt = alu_y; state_nxt = ST_Y_S; end
            ST_Y_S: begin
              rx_nxt = t0_r;
              ry_nxt = alu_y;
              if (!is_add_r && add_pend_r) begin
                state_nxt = ST_ADD_CHK;
              end else begin
                state_nxt = ST_LOOP;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      add_pend_r  <= 1'b0;
      is_add_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      ecnt_r      <= '0;
      curve_a_r   <= '0;
      prime_p_r   <= FIELD_BITS'(3);
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      add_pend_r  <= add_pend_nxt;
      is_add_r    <= is_add_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      ecnt_r      <= ecnt_nxt;
      if (cfg_we && cfg_index == REG_CURVE_A) begin
        curve_a_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_PRIME_P) begin
        prime_p_r <= cfg_data;
      end
    end
    ks_r   <= ks_nxt;
    esh_r  <= esh_nxt;
    bx_r   <= bx_nxt;
    by_r   <= by_nxt;
    ar_r   <= ar_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    tv_r   <= tv_nxt;
    tinv_r <= tinv_nxt;
    lam_r  <= lam_nxt;
    resx_r <= resx_nxt;
    resy_r <= resy_nxt;
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_result_x = resx_r;
  assign out_result_y = resy_r;

  `ECSM_ASSERT_SAME(a_idle_alu_quiet, in_ready, !alu_stat.busy && !issued_r, "ALU busy while idle")
  `ECSM_ASSERT_SAME(a_out_reduced, out_valid_r && (prime_p_r != '0), resx_r < prime_p_r && resy_r < prime_p_r, "Result not reduced")

endmodule

// ----- dv/tb_ec_scalar_multiply_gfp.sv -----
module tb_ec_scalar_multiply_gfp;
  import ecsm_pkg::*;

  localparam int FB = 64;
  localparam int WATCHDOG_LIMIT = 4000000;
  localparam logic [FB-1:0] ALL_ONES = {FB{1'b1}};
  localparam logic [FB-1:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

  typedef struct {
    logic [FB-1:0] x;
    logic [FB-1:0] y;
    logic [FB-1:0] k;
  } mult_word_t;

  typedef struct {
    logic [FB-1:0] x;
    logic [FB-1:0] y;
  } point_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [FB-1:0]          in_point_x = '0;
  logic [FB-1:0]          in_point_y = '0;
  logic [FB-1:0]          in_scalar = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [FB-1:0]          out_result_x;
  logic [FB-1:0]          out_result_y;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_CURVE_A;
  logic [FB-1:0]          cfg_data = '0;

  logic [FB-1:0] coef_a = '0;
  logic [FB-1:0] modulus = 64'd3;

  mult_word_t pending_q[$];
  point_t     product_q[$];
  int         mismatches = 0;
  bit         idling_on = 1'b1;

  ec_scalar_multiply_gfp i_dut (.*);

  always #5 clk = ~clk;

  // Field arithmetic on operands already reduced below m.
  function automatic logic [FB-1:0] f_add(logic [FB-1:0] a, logic [FB-1:0] b,
                                          logic [FB-1:0] m);
    logic [FB:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[FB-1:0];
  endfunction

  function automatic logic [FB-1:0] f_sub(logic [FB-1:0] a, logic [FB-1:0] b,
                                          logic [FB-1:0] m);
    return (a >= b) ? a - b : a - b + m;
  endfunction

  function automatic logic [FB-1:0] f_mul(logic [FB-1:0] a, logic [FB-1:0] b,
                                          logic [FB-1:0] m);
    logic [2*FB-1:0] p;
    p = ({{FB{1'b0}}, a} * {{FB{1'b0}}, b}) % {{FB{1'b0}}, m};
    return p[FB-1:0];
  endfunction

  // Inverse as v^(m-2), which is also what a non-prime modulus gets.
  function automatic logic [FB-1:0] f_inv(logic [FB-1:0] v, logic [FB-1:0] m);
    logic [FB-1:0] e;
    logic [FB-1:0] r;
    e = m - 2;
    r = 1 % m;
    for (int i = FB - 1; i >= 0; i--) begin
      r = f_mul(r, r, m);
      if (e[i]) r = f_mul(r, v, m);
    end
    return r;
  endfunction

  function automatic point_t pt_twice(point_t p, logic [FB-1:0] a, logic [FB-1:0] m);
    logic [FB-1:0] num;
    logic [FB-1:0] lam;
    point_t r;
    if (p.y == 0) begin
      r.x = 0;
      r.y = 0;
      return r;
    end
    num = f_mul(p.x, p.x, m);
    num = f_add(f_add(num, num, m), num, m);
    num = f_add(num, a, m);
    lam = f_mul(num, f_inv(f_add(p.y, p.y, m), m), m);
    r.x = f_sub(f_sub(f_mul(lam, lam, m), p.x, m), p.x, m);
    r.y = f_sub(f_mul(lam, f_sub(p.x, r.x, m), m), p.y, m);
    return r;
  endfunction

  function automatic point_t pt_sum(point_t p, point_t q, logic [FB-1:0] a,
                                    logic [FB-1:0] m);
    logic [FB-1:0] lam;
    point_t r;
    if (p.x == 0 && p.y == 0) return q;
    if (q.x == 0 && q.y == 0) return p;
    if (p.x == q.x && p.y == f_sub(0, q.y, m)) begin
      r.x = 0;
      r.y = 0;
      return r;
    end
    if (p.x == q.x && p.y == q.y) return pt_twice(p, a, m);
    lam = f_mul(f_sub(p.y, q.y, m), f_inv(f_sub(p.x, q.x, m), m), m);
    r.x = f_sub(f_sub(f_mul(lam, lam, m), p.x, m), q.x, m);
    r.y = f_sub(f_mul(lam, f_sub(p.x, r.x, m), m), p.y, m);
    return r;
  endfunction

  function automatic point_t scalar_product(mult_word_t w);
    point_t base;
    point_t acc;
    logic [FB-1:0] ar;
    int top;
    acc.x = 0;
    acc.y = 0;
    if (modulus == 0 || w.k == 0) return acc;
    base.x = w.x % modulus;
    base.y = w.y % modulus;
    ar = coef_a % modulus;
    top = FB - 1;
    while (top > 0 && !w.k[top]) top--;
    acc = base;
    for (int i = top - 1; i >= 0; i--) begin
      acc = pt_twice(acc, ar, modulus);
      if (w.k[i]) acc = pt_sum(acc, base, ar, modulus);
    end
    return acc;
  endfunction

  // Sender: a new word is taken from the pending queue only once the last one is gone.
  always @(posedge clk) begin
    bit v;
    int unsigned gap;
    mult_word_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap = 0;
    end else begin
      v = in_valid;
      if (in_valid && in_ready) begin
        product_q.push_back(scalar_product(cur));
        v = 1'b0;
      end
      if (!v) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          in_point_x <= cur.x;
          in_point_y <= cur.y;
          in_scalar <= cur.k;
          v = 1'b1;
          if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
        end
      end
      in_valid <= v;
    end
  end

  // Receiver with random stall bursts and the result check.
  always @(posedge clk) begin
    int unsigned stall;
    point_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (product_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result x=%h y=%h", out_result_x, out_result_y);
        end else begin
          want = product_q.pop_front();
          if (out_result_x !== want.x || out_result_y !== want.y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected x=%h y=%h, got x=%h y=%h",
                       want.x, want.y, out_result_x, out_result_y);
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    int unsigned quiet;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [FB-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CURVE_A) coef_a = val;
    else modulus = val;
  endtask

  task automatic set_curve(logic [FB-1:0] a, logic [FB-1:0] p);
    write_reg(REG_CURVE_A, a);
    write_reg(REG_PRIME_P, p);
  endtask

  task automatic push_word(logic [FB-1:0] x, logic [FB-1:0] y, logic [FB-1:0] k);
    mult_word_t w;
    w.x = x;
    w.y = y;
    w.k = k;
    pending_q.push_back(w);
  endtask

  function automatic logic [FB-1:0] rand_wide();
    return {$urandom(), $urandom()};
  endfunction

  // Small scalars keep the run short. Wide scalars go with an order-two point or
  // infinity, where every doubling is trivial.
  task automatic push_random(int n, bit anything);
    logic [FB-1:0] x;
    logic [FB-1:0] y;
    for (int i = 0; i < n; i++) begin
      x = rand_wide();
      y = rand_wide();
      if (anything) begin
        push_word(x, y, rand_wide());
      end else begin
        case ($urandom_range(0, 9))
          0: push_word(x, 0, rand_wide());
          1: push_word(0, 0, rand_wide());
          2: push_word(x, y, 0);
          default: push_word(x, y, $urandom_range(1, 4));
        endcase
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() != 0 || product_q.size() != 0 || in_valid);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Small field so that inverse points, order-two points and doubling of equal
    // points all come up.
    set_curve(64'd2, 64'd7);
    push_word(0, 0, 5);
    push_word(3, 4, 0);
    push_word(3, 4, 1);
    push_word(3, 0, 5);
    push_word(10, 11, 2);
    push_word(ALL_ONES, ALL_ONES, 1);
    push_word(1, 6, 2);
    push_word(1, 1, 3);
    push_word(2, 5, 4);
    push_word(0, 3, 3);
    push_word(5, 0, ALL_ONES);
    push_word(0, 0, 64'h8000_0000_0000_0000);
    drain();

    set_curve(ALL_ONES, 64'd0);
    push_random(4, 1'b1);
    drain();

    set_curve(rand_wide(), 64'd1);
    push_random(6, 1'b1);
    drain();

    set_curve(ALL_ONES, 64'd15);
    push_random(8, 1'b0);
    drain();

    set_curve(rand_wide(), BIG_PRIME);
    push_word(ALL_ONES, ALL_ONES, 2);
    push_word(BIG_PRIME, 1, 3);
    push_random(14, 1'b0);
    drain();

    set_curve(ALL_ONES, ALL_ONES);
    push_random(8, 1'b0);
    drain();

    set_curve(64'd0, 64'd11);
    push_random(12, 1'b0);
    drain();

    set_curve(64'd1, 64'd13);
    push_random(12, 1'b0);
    drain();

    idling_on = 1'b0;
    set_curve(64'd3, 64'd5);
    push_random(14, 1'b0);
    drain();

    if (mismatches == 0 && product_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
